// ----- rtl/core/scps_pkg.sv -----
package scps_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CHUNK_W   = 32;
    localparam int MUL_A_W   = 96;
    localparam int MUL_B_W   = 64;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int POT_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CUTOFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SCALE = 2'd2;

    typedef enum logic [2:0] {
        MS_DX, MS_DY, MS_DZ, MS_CM, MS_CW, MS_P
    } mul_sel_t;

    typedef enum logic {
        DS_RINV, DS_Q
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DX_GO, ST_DX_WT, ST_DY_GO, ST_DY_WT, ST_DZ_GO, ST_DZ_WT,
        ST_RSUM, ST_RCHK,
        ST_SQ_GO, ST_SQ_WT,
        ST_RV_GO, ST_RV_WT,
        ST_DIFF,
        ST_CM_GO, ST_CM_WT,
        ST_Q_GO, ST_Q_WT,
        ST_CW_GO, ST_CW_WT,
        ST_P_GO, ST_P_WT,
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     div_go;
        div_sel_t div_sel;
        logic     sqrt_go;
        logic     diff;
        logic     acc;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic outside;
        logic last;
        logic out_full;
    } dp_stat_t;

endpackage

// ----- rtl/core/scps_mul.sv -----
module scps_mul
    import scps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_P_W-1:0]   acc_reg;
    logic [2*CHUNK_W-1:0] pp_reg;
    logic [1:0]           sh_reg;
    logic [1:0]           ai_reg;
    logic                 bi_reg;
    logic                 run_reg;
    logic                 pend_reg;
    logic                 done_reg;
    logic [MUL_P_W-1:0]   pp_ext;

    // one 32x32 partial product a cycle, added into the sum in the following cycle
    assign pp_ext = {{(MUL_P_W-2*CHUNK_W){1'b0}}, pp_reg} << {sh_reg, 5'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= pend_reg && !run_reg;
            pend_reg <= run_reg;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && ai_reg == 2'd2 && bi_reg) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            ai_reg  <= 2'd0;
            bi_reg  <= 1'b0;
        end else begin
            if (pend_reg) begin
                acc_reg <= acc_reg + pp_ext;
            end
            if (run_reg) begin
                pp_reg <= a_reg[ai_reg*CHUNK_W +: CHUNK_W] * b_reg[bi_reg*CHUNK_W +: CHUNK_W];
                sh_reg <= ai_reg + {1'b0, bi_reg};
                bi_reg <= !bi_reg;
                if (bi_reg) begin
                    ai_reg <= ai_reg + 2'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/core/scps_div.sv -----
module scps_div
    import scps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quot
);

    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quot_reg;
    logic [5:0]         cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   rem_sub;
    logic               ge;

    // restoring division, one quotient bit a cycle; a zero divisor gives all ones
    assign rem_sh  = {rem_reg, num_reg[DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (&cnt_reg);
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && (&cnt_reg)) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
        end else if (run_reg) begin
            num_reg  <= {num_reg[DIV_N_W-2:0], 1'b0};
            rem_reg  <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            quot_reg <= {quot_reg[DIV_N_W-2:0], ge};
            cnt_reg  <= cnt_reg + 6'd1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/scps_datapath.sv -----
module scps_datapath
    import scps_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [287:0]         s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [POT_W-1:0]     m_tdata,
    output logic                 m_tuser
);

    localparam int LIM_W  = 32 + FRAC_BITS;
    localparam int RINV_W = 2 * FRAC_BITS + 1;
    localparam int DIFF_W = ((RINV_W > 32) ? RINV_W : 32) + 1;
    localparam int CW_SAT = 47 + 2 * FRAC_BITS;
    localparam int P_SAT  = 47 + FRAC_BITS;
    localparam logic signed [POT_W:0] POT_MAX = (49'sd1 <<< 47) - 49'sd1;
    localparam logic signed [POT_W:0] POT_MIN = -(49'sd1 <<< 47);

    logic [31:0]        cut_sq_reg, inv_cut_reg;
    logic [47:0]        scale_reg;
    logic [31:0]        dmx_reg, dmy_reg, dmz_reg;
    logic [31:0]        conc_reg, mass_reg, dens_reg;
    logic               last_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [65:0]        rsq_reg;
    logic [31:0]        r_reg;
    logic [RINV_W-1:0]  rinv_reg;
    logic [DIFF_W-1:0]  mag_reg;
    logic               neg_reg;
    logic [63:0]        num_reg, q_reg;
    logic [MUL_A_W-1:0] cw_reg;
    logic               cw_sat_reg, p_sat_reg;
    logic [46:0]        tmag_reg;
    logic [POT_W-1:0]   sum_reg;
    logic               flag_reg;
    logic               m_valid_reg;
    logic [POT_W-1:0]   m_data_reg;
    logic               m_user_reg;

    logic [63:0]        sq_rad_reg;
    logic [32:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [4:0]         sq_cnt_reg;
    logic               sq_run_reg, sq_done_reg;
    logic [34:0]        sq_sh, sq_trial, sq_sub;
    logic               sq_ge;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic               mul_done;
    logic [DIV_N_W-1:0] div_n, quot;
    logic [DIV_D_W-1:0] div_d;
    logic               div_done;

    logic [LIM_W-1:0]   lim;
    logic [DIFF_W-1:0]  diff;
    logic signed [POT_W:0] addend, acc_sum;
    logic               term_sat;

    function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        absdiff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    always_comb begin
        unique case (cmd.mul_sel)
            MS_DX:   begin mul_a = MUL_A_W'(dmx_reg);   mul_b = MUL_B_W'(dmx_reg);  end
            MS_DY:   begin mul_a = MUL_A_W'(dmy_reg);   mul_b = MUL_B_W'(dmy_reg);  end
            MS_DZ:   begin mul_a = MUL_A_W'(dmz_reg);   mul_b = MUL_B_W'(dmz_reg);  end
            MS_CM:   begin mul_a = MUL_A_W'(conc_reg);  mul_b = MUL_B_W'(mass_reg); end
            MS_CW:   begin mul_a = MUL_A_W'(scale_reg); mul_b = q_reg;              end
            MS_P:    begin mul_a = cw_reg;              mul_b = MUL_B_W'(mag_reg);  end
            default: begin mul_a = '0;                  mul_b = '0;                 end
        endcase
    end

    always_comb begin
        unique case (cmd.div_sel)
            DS_RINV: begin div_n = 64'd1 << (2 * FRAC_BITS); div_d = r_reg;    end
            default: begin div_n = num_reg;                  div_d = dens_reg; end
        endcase
    end

    scps_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mul_go),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
    );

    scps_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_go),
        .dividend(div_n), .divisor(div_d), .done(div_done), .quot(quot)
    );

    // digit-by-digit square root, two radicand bits a cycle
    assign sq_sh    = {sq_rem_reg, sq_rad_reg[63:62]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_sub   = sq_sh - sq_trial;

    assign lim  = {cut_sq_reg, {FRAC_BITS{1'b0}}};
    assign diff = DIFF_W'(rinv_reg) - DIFF_W'(inv_cut_reg);

    always_comb begin
        term_sat = cw_sat_reg || p_sat_reg;
        if (term_sat) begin
            addend = neg_reg ? POT_MIN : POT_MAX;
        end else begin
            addend = neg_reg ? -$signed({2'b00, tmag_reg}) : $signed({2'b00, tmag_reg});
        end
        acc_sum = $signed({sum_reg[POT_W-1], sum_reg}) + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_sq_reg  <= '0;
            inv_cut_reg <= '0;
            scale_reg   <= '0;
            sum_reg     <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            sq_run_reg  <= 1'b0;
            sq_done_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CUTOFF_SQ:    cut_sq_reg  <= cfg_data[31:0];
                    CFG_INV_CUTOFF:   inv_cut_reg <= cfg_data[31:0];
                    CFG_CHARGE_SCALE: scale_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            sq_done_reg <= sq_run_reg && (&sq_cnt_reg);
            if (cmd.sqrt_go) begin
                sq_run_reg <= 1'b1;
            end else if (sq_run_reg && (&sq_cnt_reg)) begin
                sq_run_reg <= 1'b0;
            end
            if (cmd.acc && mag_reg != '0) begin
                if (acc_sum > POT_MAX) begin
                    sum_reg  <= POT_MAX[POT_W-1:0];
                    flag_reg <= 1'b1;
                end else if (acc_sum < POT_MIN) begin
                    sum_reg  <= POT_MIN[POT_W-1:0];
                    flag_reg <= 1'b1;
                end else begin
                    sum_reg  <= acc_sum[POT_W-1:0];
                    flag_reg <= flag_reg || term_sat;
                end
            end
            if (cmd.emit) begin
                sum_reg     <= '0;
                flag_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rsq_reg <= 66'(sqx_reg) + 66'(sqy_reg) + 66'(sqz_reg);
        if (cmd.load) begin
            dmx_reg  <= absdiff(s_tdata[31:0], s_tdata[127:96]);
            dmy_reg  <= absdiff(s_tdata[63:32], s_tdata[159:128]);
            dmz_reg  <= absdiff(s_tdata[95:64], s_tdata[191:160]);
            conc_reg <= s_tdata[223:192];
            mass_reg <= s_tdata[255:224];
            dens_reg <= s_tdata[287:256];
            last_reg <= s_tlast;
        end
        if (cmd.sqrt_go) begin
            sq_rad_reg  <= rsq_reg[63:0];
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end else if (sq_run_reg) begin
            sq_rad_reg  <= {sq_rad_reg[61:0], 2'b00};
            sq_rem_reg  <= sq_ge ? sq_sub[32:0] : sq_sh[32:0];
            sq_root_reg <= {sq_root_reg[30:0], sq_ge};
            sq_cnt_reg  <= sq_cnt_reg + 5'd1;
        end
        if (sq_done_reg) begin
            r_reg <= (sq_root_reg == '0) ? 32'd1 : sq_root_reg;
        end
        if (mul_done) begin
            unique case (cmd.mul_sel)
                MS_DX: sqx_reg <= prod[63:0];
                MS_DY: sqy_reg <= prod[63:0];
                MS_DZ: sqz_reg <= prod[63:0];
                MS_CM: num_reg <= prod[63:0];
                MS_CW: begin
                    cw_reg     <= prod[FRAC_BITS +: MUL_A_W];
                    cw_sat_reg <= |prod[MUL_P_W-1:CW_SAT];
                end
                MS_P: begin
                    p_sat_reg <= |prod[MUL_P_W-1:P_SAT];
                    tmag_reg  <= prod[FRAC_BITS +: 47];
                end
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (cmd.div_sel)
                DS_RINV: rinv_reg <= quot[RINV_W-1:0];
                default: q_reg    <= quot;
            endcase
        end
        if (cmd.diff) begin
            neg_reg <= diff[DIFF_W-1];
            mag_reg <= diff[DIFF_W-1] ? -diff : diff;
        end
        if (cmd.emit) begin
            m_data_reg <= sum_reg;
            m_user_reg <= flag_reg;
        end
    end

    always_comb begin
        stat.mul_done  = mul_done;
        stat.div_done  = div_done;
        stat.sqrt_done = sq_done_reg;
        stat.outside   = (sqx_reg >= 64'(lim)) || (sqy_reg >= 64'(lim)) ||
                         (sqz_reg >= 64'(lim)) || (rsq_reg >= 66'(lim));
        stat.last      = last_reg;
        stat.out_full  = m_valid_reg && !m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_done && div_done) && !(mul_done && sq_done_reg))
        else $error("two arithmetic units finished together");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (sum_reg == '0) && !flag_reg && m_valid_reg)
        else $error("sum not cleared after emit");

    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done_reg |=> r_reg != '0)
        else $error("zero distance root");

    a_no_emit_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !m_tready))
        else $error("result overwritten before taken");

endmodule

// ----- rtl/core/scps_ctrl.sv -----
module scps_ctrl
    import scps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = s_tuser ? ST_EMIT : ST_DX_GO;
            ST_DX_GO: state_next = ST_DX_WT;
            ST_DX_WT: if (stat.mul_done) state_next = ST_DY_GO;
            ST_DY_GO: state_next = ST_DY_WT;
            ST_DY_WT: if (stat.mul_done) state_next = ST_DZ_GO;
            ST_DZ_GO: state_next = ST_DZ_WT;
            ST_DZ_WT: if (stat.mul_done) state_next = ST_RSUM;
            ST_RSUM:  state_next = ST_RCHK;
            ST_RCHK: begin
                if (!stat.outside)  state_next = ST_SQ_GO;
                else if (stat.last) state_next = ST_EMIT;
                else                state_next = ST_IDLE;
            end
            ST_SQ_GO: state_next = ST_SQ_WT;
            ST_SQ_WT: if (stat.sqrt_done) state_next = ST_RV_GO;
            ST_RV_GO: state_next = ST_RV_WT;
            ST_RV_WT: if (stat.div_done) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_CM_GO;
            ST_CM_GO: state_next = ST_CM_WT;
            ST_CM_WT: if (stat.mul_done) state_next = ST_Q_GO;
            ST_Q_GO:  state_next = ST_Q_WT;
            ST_Q_WT:  if (stat.div_done) state_next = ST_CW_GO;
            ST_CW_GO: state_next = ST_CW_WT;
            ST_CW_WT: if (stat.mul_done) state_next = ST_P_GO;
            ST_P_GO:  state_next = ST_P_WT;
            ST_P_WT:  if (stat.mul_done) state_next = ST_ACC;
            ST_ACC:   state_next = stat.last ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (!stat.out_full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MS_DX;
        cmd.div_sel = DS_RINV;
        cmd.load    = accept;
        unique case (state_reg)
            ST_DX_GO: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_DX; end
            ST_DX_WT: cmd.mul_sel = MS_DX;
            ST_DY_GO: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_DY; end
            ST_DY_WT: cmd.mul_sel = MS_DY;
            ST_DZ_GO: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_DZ; end
            ST_DZ_WT: cmd.mul_sel = MS_DZ;
            ST_SQ_GO: cmd.sqrt_go = 1'b1;
            ST_RV_GO: begin cmd.div_go = 1'b1; cmd.div_sel = DS_RINV; end
            ST_RV_WT: cmd.div_sel = DS_RINV;
            ST_DIFF:  cmd.diff = 1'b1;
            ST_CM_GO: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_CM; end
            ST_CM_WT: cmd.mul_sel = MS_CM;
            ST_Q_GO:  begin cmd.div_go = 1'b1; cmd.div_sel = DS_Q; end
            ST_Q_WT:  cmd.div_sel = DS_Q;
            ST_CW_GO: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_CW; end
            ST_CW_WT: cmd.mul_sel = MS_CW;
            ST_P_GO:  begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_P; end
            ST_P_WT:  cmd.mul_sel = MS_P;
            ST_ACC:   cmd.acc = 1'b1;
            ST_EMIT:  cmd.emit = !stat.out_full;
            default:  ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- rtl/core/shifted_coulomb_potential_sum_top.sv -----
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    s_tdata pair fields, s_tlast, s_tuser
// m_       out  m_tvalid / m_tready    m_tdata potential, m_tuser overflow
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pair inside the cutoff runs three squares and three
// products on the shared 96x64 multiplier (six 32x32 partial products
// each), a 32-step square root, and two 64-step divisions on the
// shared divider.
// A pair outside the cutoff ends after its squares; a no-neighbor beat goes to emit.
// Reset (aresetn low, synchronous) clears the configuration registers, the sum and the flag.
// A held result stalls only the emitting beat; pairs are taken meanwhile.
module shifted_coulomb_potential_sum_top
    import scps_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z,
    // neighbor_conc, neighbor_mass, neighbor_density (32 bits each)
    input  logic [287:0]         s_tdata,
    input  logic                 s_tlast,   // last_neighbor
    input  logic                 s_tuser,   // no_neighbors
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [POT_W-1:0]     m_tdata,   // atom_potential
    output logic                 m_tuser,   // overflow
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    scps_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tuser(s_tuser), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    scps_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule
